// ----- rtl/rc4_pkg.sv -----
// Shared constants, codes and types of the RC4 stream cipher.
package rc4_pkg;

   localparam int BYTE_W          = 8;
   localparam int PERM_DEPTH      = 256;
   localparam int PERM_AW         = 8;
   localparam int KEY_MAX_DEFAULT = 256;

   localparam logic KIND_KEY  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

   localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

   typedef struct packed {
      logic [BYTE_W-1:0] result_byte;
      logic              result_last;
      logic              no_key;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILL,
      ST_K0,
      ST_K1,
      ST_K2,
      ST_K3,
      ST_P1,
      ST_P2,
      ST_P3
   } engine_state_type;

endpackage

// ----- rtl/rc4_if.sv -----
// Request and response channel interfaces of the RC4 stream cipher.
interface rc4_req_if import rc4_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BYTE_W-1:0] value;
   logic              last;

   modport source (output valid, output kind, output value, output last, input ready);
   modport sink (input valid, input kind, input value, input last, output ready);
endinterface

interface rc4_rsp_if import rc4_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] result_byte;
   logic              result_last;
   logic              no_key;

   modport source (output valid, output result_byte, output result_last, output no_key,
                   input ready);
   modport sink (input valid, input result_byte, input result_last, input no_key,
                 output ready);
endinterface

// ----- rtl/rc4_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rc4_ram import rc4_pkg::*; #(
   parameter int WIDTH = BYTE_W,
   parameter int DEPTH = PERM_DEPTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rc4_engine.sv -----
// Key store, permutation memory and the sequencer for key schedule and keystream.
module rc4_engine import rc4_pkg::*; #(
   parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rc4_req_if.sink    req_bus,
   output result_type res_data,
   output logic       res_valid,
   input  logic       res_take
);

   localparam int KEY_AW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
   localparam int KLEN_W = $clog2(KEY_MAX + 1);

   engine_state_type    state_ff, state_in;
   logic [PERM_AW-1:0]  idx_i_ff, idx_i_in;
   logic [PERM_AW-1:0]  idx_j_ff, idx_j_in;
   logic [PERM_AW-1:0]  n_ff, n_in;
   logic [KEY_AW-1:0]   k_ff, k_in;
   logic [KLEN_W-1:0]   key_len_ff, key_len_in;
   logic                keyed_ff, keyed_in;
   logic [BYTE_W-1:0]   si_ff, si_in;
   logic [BYTE_W-1:0]   sj_ff, sj_in;
   logic [PERM_AW-1:0]  t_ff, t_in;
   logic [BYTE_W-1:0]   value_ff, value_in;
   logic                last_ff, last_in;
   result_type          res_ff, res_in;
   logic                res_valid_ff, res_valid_in;

   logic                accept;

   logic                p_we;
   logic [PERM_AW-1:0]  p_waddr;
   logic [BYTE_W-1:0]   p_wdata;
   logic [PERM_AW-1:0]  p_raddr;
   logic [BYTE_W-1:0]   p_rdata;
   logic                k_we;
   logic [KEY_AW-1:0]   k_waddr;
   logic [BYTE_W-1:0]   k_rdata;

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(PERM_DEPTH)) u_perm_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   rc4_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_MAX)) u_key_ram (
      .clock   (clock),
      .wr_en   (k_we),
      .wr_addr (k_waddr),
      .wr_data (req_bus.value),
      .rd_addr (k_ff),
      .rd_data (k_rdata)
   );

   assign req_bus.ready = (state_ff == ST_IDLE) && (!res_valid_ff || res_take);
   assign accept        = req_bus.valid && req_bus.ready;
   assign res_data      = res_ff;
   assign res_valid     = res_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.kind == KIND_KEY) begin
                  if (req_bus.last) begin
                     state_in = ST_FILL;
                  end
               end else if (keyed_ff) begin
                  state_in = ST_P1;
               end
            end
         end
         ST_FILL: begin
            if (n_ff == PERM_LAST) begin
               state_in = ST_K0;
            end
         end
         ST_K0: state_in = ST_K1;
         ST_K1: state_in = ST_K2;
         ST_K2: state_in = ST_K3;
         ST_K3: begin
            state_in = (n_ff == PERM_LAST) ? ST_IDLE : ST_K0;
         end
         ST_P1: state_in = ST_P2;
         ST_P2: state_in = ST_P3;
         ST_P3: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      logic [PERM_AW-1:0] acc;
      logic [BYTE_W-1:0]  ks;

      acc          = '0;
      ks           = '0;
      idx_i_in     = idx_i_ff;
      idx_j_in     = idx_j_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      key_len_in   = key_len_ff;
      keyed_in     = keyed_ff;
      si_in        = si_ff;
      sj_in        = sj_ff;
      t_in         = t_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      res_in       = res_ff;
      res_valid_in = res_valid_ff && !res_take;
      p_we         = 1'b0;
      p_waddr      = n_ff;
      p_wdata      = n_ff;
      p_raddr      = n_ff;
      k_we         = 1'b0;
      k_waddr      = key_len_ff[KEY_AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            p_raddr = idx_i_ff + 1'b1;
            if (accept) begin
               if (req_bus.kind == KIND_KEY) begin
                  // drop key bytes beyond the store
                  if (key_len_ff < KLEN_W'(KEY_MAX)) begin
                     k_we       = 1'b1;
                     key_len_in = key_len_ff + 1'b1;
                  end
                  if (req_bus.last) begin
                     n_in     = '0;
                     k_in     = '0;
                     idx_j_in = '0;
                  end
               end else if (keyed_ff) begin
                  idx_i_in = idx_i_ff + 1'b1;
                  value_in = req_bus.value;
                  last_in  = req_bus.last;
               end else begin
                  res_in       = '{result_byte: req_bus.value, result_last: req_bus.last,
                                   no_key: 1'b1};
                  res_valid_in = 1'b1;
               end
            end
         end
         ST_FILL: begin
            p_we    = 1'b1;
            p_waddr = n_ff;
            p_wdata = n_ff;
            n_in    = n_ff + 1'b1;
         end
         ST_K0: begin
            p_raddr = n_ff;
         end
         ST_K1: begin
            acc      = idx_j_ff + p_rdata + k_rdata;
            idx_j_in = acc;
            si_in    = p_rdata;
            p_raddr  = acc;
         end
         ST_K2: begin
            p_we    = 1'b1;
            p_waddr = n_ff;
            p_wdata = p_rdata;
         end
         ST_K3: begin
            p_we    = 1'b1;
            p_waddr = idx_j_ff;
            p_wdata = si_ff;
            n_in    = n_ff + 1'b1;
            k_in    = (KLEN_W'(k_ff) == key_len_ff - 1'b1) ? '0 : k_ff + 1'b1;
            if (n_ff == PERM_LAST) begin
               idx_i_in   = '0;
               idx_j_in   = '0;
               keyed_in   = 1'b1;
               key_len_in = '0;
            end
         end
         ST_P1: begin
            acc      = idx_j_ff + p_rdata;
            idx_j_in = acc;
            si_in    = p_rdata;
            p_raddr  = acc;
         end
         ST_P2: begin
            // first half of the swap; the read at t sees the old contents
            p_we    = 1'b1;
            p_waddr = idx_i_ff;
            p_wdata = p_rdata;
            sj_in   = p_rdata;
            acc     = si_ff + p_rdata;
            t_in    = acc;
            p_raddr = acc;
         end
         ST_P3: begin
            p_we    = 1'b1;
            p_waddr = idx_j_ff;
            p_wdata = si_ff;
            // forward the swapped entries over the stale read
            if (t_ff == idx_j_ff) begin
               ks = si_ff;
            end else if (t_ff == idx_i_ff) begin
               ks = sj_ff;
            end else begin
               ks = p_rdata;
            end
            res_in       = '{result_byte: value_ff ^ ks, result_last: last_ff, no_key: 1'b0};
            res_valid_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_i_ff     <= '0;
         idx_j_ff     <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         key_len_ff   <= '0;
         keyed_ff     <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_i_ff     <= idx_i_in;
         idx_j_ff     <= idx_j_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         key_len_ff   <= key_len_in;
         keyed_ff     <= keyed_in;
         res_valid_ff <= res_valid_in;
      end
      si_ff    <= si_in;
      sj_ff    <= sj_in;
      t_ff     <= t_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
   end

endmodule

// ----- rtl/rc4_rsp_reg.sv -----
// Output register of the response channel.
module rc4_rsp_reg import rc4_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type res_data,
   input  logic       res_valid,
   output logic       res_take,
   rc4_rsp_if.source  rsp_bus
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff, rsp_data_in;

   assign res_take = res_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      rsp_valid_in = res_take || (rsp_valid_ff && !rsp_bus.ready);
      rsp_data_in  = res_take ? res_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.result_byte = rsp_data_ff.result_byte;
   assign rsp_bus.result_last = rsp_data_ff.result_last;
   assign rsp_bus.no_key      = rsp_data_ff.no_key;

endmodule

// ----- rtl/rc4_stream_cipher.sv -----
// RC4 stream cipher: key loading, in-block key schedule and keystream XOR.
//
// Requests enter on req_bus (valid/ready); kind selects a key byte or a data
// byte. Key bytes are stored in a key RAM of KEY_MAX entries; extra bytes are
// dropped. The key byte marked last starts the schedule: the identity
// permutation is loaded, then 256 steps run through the states K0 to K3,
// and all the while req_bus.ready stays low.
// A data byte yields one response on rsp_bus: the byte XORed with the next
// keystream byte, its last mark, and no_key set when no key has been
// scheduled (byte returned unchanged). A keyed data byte runs through the
// states P1, P2 and P3 into the result register, with no request taken
// before idle; an unkeyed one goes straight to the result register. Three
// dependent reads per byte on the single read port of the permutation RAM set
// this order, swap writes forwarded. A non-last key byte gives no response.
// The response sits in an output register; while the receiver stalls it
// holds, and one more finished result can wait inside before requests stop.
// Reset clears the indices, key count and the keyed flag; the RAM contents
// are left as they are.
module rc4_stream_cipher import rc4_pkg::*; #(
   parameter int KEY_MAX = KEY_MAX_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   rc4_req_if.sink   req_bus,
   rc4_rsp_if.source rsp_bus
);

   result_type res_data;
   logic       res_valid;
   logic       res_take;

   rc4_engine #(.KEY_MAX(KEY_MAX)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .res_data  (res_data),
      .res_valid (res_valid),
      .res_take  (res_take)
   );

   rc4_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .res_data  (res_data),
      .res_valid (res_valid),
      .res_take  (res_take),
      .rsp_bus   (rsp_bus)
   );

endmodule

// ----- rtl/rc4_checker.sv -----
// Port-level checks of the RC4 stream cipher, bound to the top level.
module rc4_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_kind,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_result_byte,
   input logic       rsp_result_last,
   input logic       rsp_no_key
);

   // no response survives a reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_byte)
         && $stable(rsp_result_last) && $stable(rsp_no_key))
      else $error("stalled response changed");

   // the last key byte starts the schedule, which blocks requests
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind && req_last |=> !req_ready)
      else $error("request accepted while key schedule starts");

   // a schedule lasts beyond a few cycles
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_kind && req_last |=> ##4 !req_ready)
      else $error("key schedule ended too early");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_bus.valid),
   .req_ready       (req_bus.ready),
   .req_kind        (req_bus.kind),
   .req_last        (req_bus.last),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_result_byte (rsp_bus.result_byte),
   .rsp_result_last (rsp_bus.result_last),
   .rsp_no_key      (rsp_bus.no_key)
);

// ----- tb/testbench.sv -----
// Self-checking testbench of the RC4 stream cipher: directed table, then random traffic.
module testbench import rc4_pkg::*; ();

   localparam int STALL_LIMIT = 8000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic              kind;
      logic [BYTE_W-1:0] value;
      logic              last;
      int                reps;
      bit                typed;
      logic [BYTE_W-1:0] want_byte;
      logic              want_no_key;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset;

   rc4_req_if req_bus ();
   rc4_rsp_if rsp_bus ();

   rc4_stream_cipher DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // cipher state as predicted
   logic [BYTE_W-1:0] sbox [PERM_DEPTH];
   logic [BYTE_W-1:0] key_bytes [PERM_DEPTH];
   int                key_count;
   logic [BYTE_W-1:0] ks_i;
   logic [BYTE_W-1:0] ks_j;
   bit                have_key;

   result_type pending_results [$];
   int         mismatches = 0;
   int         requests_sent = 0;
   int         responses_seen = 0;
   int         stall_cycles = 0;
   bit         quiet_phase = 1'b0;

   // a key byte marked last runs the schedule, even when the byte itself is dropped
   function automatic void absorb_key_byte(logic [BYTE_W-1:0] value, logic last);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] t;
      if (key_count < KEY_MAX_DEFAULT) begin
         key_bytes[key_count] = value;
         key_count++;
      end
      if (last) begin
         for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = BYTE_W'(n);
         acc = '0;
         for (int n = 0; n < PERM_DEPTH; n++) begin
            acc = acc + sbox[n] + key_bytes[n % key_count];
            t = sbox[n];
            sbox[n] = sbox[acc];
            sbox[acc] = t;
         end
         ks_i = '0;
         ks_j = '0;
         have_key = 1'b1;
         key_count = 0;
      end
   endfunction

   function automatic result_type cipher_byte(logic [BYTE_W-1:0] value, logic last);
      result_type r;
      logic [BYTE_W-1:0] t;
      r.result_last = last;
      if (!have_key) begin
         r.result_byte = value;
         r.no_key = 1'b1;
      end else begin
         ks_i = ks_i + 1'b1;
         ks_j = ks_j + sbox[ks_i];
         t = sbox[ks_i];
         sbox[ks_i] = sbox[ks_j];
         sbox[ks_j] = t;
         r.result_byte = value ^ sbox[BYTE_W'(sbox[ks_i] + sbox[ks_j])];
         r.no_key = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0h expected %0h",
               responses_seen, what, got, want);
      mismatches++;
   endtask

   // entered and left at a falling edge; valid is left high on return
   task automatic send_request(logic kind, logic [BYTE_W-1:0] value, logic last,
                               bit typed = 1'b0, result_type want = '0);
      quiet_phase = (requests_sent >= 500 && requests_sent < 750);
      while (!quiet_phase && $urandom_range(99) < 35) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.kind  <= kind;
      req_bus.value <= value;
      req_bus.last  <= last;
      do @(posedge clock); while (!req_bus.ready);
      if (kind == KIND_KEY) absorb_key_byte(value, last);
      else pending_results.push_back(typed ? want : cipher_byte(value, last));
      requests_sent++;
      @(negedge clock);
   endtask

   // hold off until every predicted response has come back
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 35);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         responses_seen++;
         if (pending_results.size() == 0) begin
            report_mismatch("response with none expected", rsp_bus.result_byte, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.result_byte !== want.result_byte)
               report_mismatch("result_byte", rsp_bus.result_byte, want.result_byte);
            if (rsp_bus.result_last !== want.result_last)
               report_mismatch("result_last", rsp_bus.result_last, want.result_last);
            if (rsp_bus.no_key !== want.no_key)
               report_mismatch("no_key", rsp_bus.no_key, want.no_key);
         end
      end
   end

   // the key schedule alone keeps the request side stalled, well within STALL_LIMIT
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   directed_row_type directed_rows [20] = '{
      // data before any key comes back unchanged with no_key
      '{KIND_DATA, 8'h00, 1'b0, 1,   1'b1, 8'h00, 1'b1},
      '{KIND_DATA, 8'hFF, 1'b1, 1,   1'b1, 8'hFF, 1'b1},
      '{KIND_DATA, 8'h5A, 1'b0, 1,   1'b1, 8'h5A, 1'b1},
      // a key under way is not yet in use
      '{KIND_KEY,  8'h01, 1'b0, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'h33, 1'b1, 1,   1'b1, 8'h33, 1'b1},
      '{KIND_KEY,  8'hFF, 1'b0, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_KEY,  8'h00, 1'b1, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'h00, 1'b0, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'hFF, 1'b1, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'h80, 1'b0, 3,   1'b0, 8'h00, 1'b0},
      // one-byte key
      '{KIND_KEY,  8'h00, 1'b1, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'hFF, 1'b1, 4,   1'b0, 8'h00, 1'b0},
      // key store filled exactly
      '{KIND_KEY,  8'hFF, 1'b1, 256, 1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'h00, 1'b1, 3,   1'b0, 8'h00, 1'b0},
      // overflow: the last byte is dropped but still starts the schedule
      '{KIND_KEY,  8'h3C, 1'b1, 300, 1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'h01, 1'b0, 3,   1'b0, 8'h00, 1'b0},
      // old permutation stays in use while the next key is collected
      '{KIND_KEY,  8'h77, 1'b0, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'hAA, 1'b1, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_KEY,  8'h11, 1'b1, 1,   1'b0, 8'h00, 1'b0},
      '{KIND_DATA, 8'h55, 1'b1, 2,   1'b0, 8'h00, 1'b0}
   };

   initial begin
      int   len;
      int   sel;
      logic row_last;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.kind = KIND_KEY;
      req_bus.value = '0;
      req_bus.last = 1'b0;
      rsp_bus.ready = 1'b0;
      key_count = 0;
      ks_i = '0;
      ks_j = '0;
      have_key = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            row_last = (k == directed_rows[r].reps - 1) ? directed_rows[r].last : 1'b0;
            send_request(directed_rows[r].kind, directed_rows[r].value, row_last,
                         directed_rows[r].typed,
                         '{directed_rows[r].want_byte, row_last, directed_rows[r].want_no_key});
         end
      end
      drain_responses();

      while (requests_sent < RANDOM_ITEMS) begin
         sel = $urandom_range(99);
         if (sel < 70) begin
            // well-formed: a whole key, then a message
            sel = $urandom_range(29);
            if (sel == 0) len = $urandom_range(257, 270);
            else if (sel < 3) len = $urandom_range(200, 256);
            else len = $urandom_range(1, 16);
            for (int k = 0; k < len; k++)
               send_request(KIND_KEY, BYTE_W'($urandom_range(255)), k == len - 1);
            len = $urandom_range(1, 40);
            for (int k = 0; k < len; k++)
               send_request(KIND_DATA, BYTE_W'($urandom_range(255)), k == len - 1);
         end else if (sel < 85) begin
            len = $urandom_range(1, 10);
            for (int k = 0; k < len; k++)
               send_request(KIND_DATA, BYTE_W'($urandom_range(255)), $urandom_range(1));
         end else if (sel < 95) begin
            // key left open, message meanwhile runs on the old permutation
            len = $urandom_range(1, 5);
            for (int k = 0; k < len; k++)
               send_request(KIND_KEY, BYTE_W'($urandom_range(255)), 1'b0);
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++)
               send_request(KIND_DATA, BYTE_W'($urandom_range(255)), $urandom_range(1));
         end else begin
            drain_responses();
         end
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
